// ----- design/ctl_pkg.sv -----
// shared types and constants for the closed tour length block
`default_nettype none

package ctl_pkg;

    localparam int CTL_COORD_W   = 24;
    localparam int CTL_SUM_W     = 48;
    localparam int CTL_FRAC_BITS = 8;

    // magnitude of a coordinate difference, its square sum and its root
    localparam int CTL_DIFF_W = CTL_COORD_W + 1;
    localparam int CTL_SQ_W   = 2 * CTL_DIFF_W;
    localparam int CTL_ROOT_W = CTL_SQ_W / 2;

    // att pseudo-euclidean divisor
    localparam int CTL_ATT_DIV = 10;

    localparam logic [CTL_SUM_W-1:0] CTL_SUM_MAX = '1;

    typedef enum logic {
        MODE_EUC = 1'b0,
        MODE_ATT = 1'b1
    } t_ctl_mode;

    typedef struct packed {
        logic signed [CTL_COORD_W-1:0] city_x;
        logic signed [CTL_COORD_W-1:0] city_y;
        logic                          is_final;
    } t_ctl_in;

    typedef struct packed {
        logic [CTL_SUM_W-1:0] total_length;
        logic                 overflowed;
    } t_ctl_out;

endpackage

`default_nettype wire

// ----- design/ctl_sqdist.sv -----
// squared distance unit: one shared multiplier squares dx, then dy, and the squares are summed
`default_nettype none

module ctl_sqdist #(
    parameter int CW = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [CW-1:0]        i_ax,
    input  wire logic [CW-1:0]        i_ay,
    input  wire logic [CW-1:0]        i_bx,
    input  wire logic [CW-1:0]        i_by,
    output logic                      o_done,
    output logic [2*CW+1:0]           o_sq
);

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_MX,
        SQ_MY,
        SQ_SUM
    } t_sq_state;

    t_sq_state          r_state;
    logic               r_done;
    logic [CW:0]        r_dx;
    logic [CW:0]        r_dy;
    logic [2*CW+1:0]    r_prod;
    logic [2*CW+1:0]    r_acc;

    logic [CW:0]        dx_raw;
    logic [CW:0]        dy_raw;
    logic [CW:0]        dx_abs;
    logic [CW:0]        dy_abs;
    logic [CW:0]        mul_op;
    logic [2*CW+1:0]    product;

    always_comb begin
        dx_raw  = {i_bx[CW-1], i_bx} - {i_ax[CW-1], i_ax};
        dy_raw  = {i_by[CW-1], i_by} - {i_ay[CW-1], i_ay};
        // two's complement negate; the most negative difference maps to 2^CW - 1
        dx_abs  = dx_raw[CW] ? (~dx_raw + 1'b1) : dx_raw;
        dy_abs  = dy_raw[CW] ? (~dy_raw + 1'b1) : dy_raw;
        mul_op  = (r_state == SQ_MX) ? r_dx : r_dy;
        product = (2*CW+2)'(mul_op) * (2*CW+2)'(mul_op);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                SQ_IDLE: begin
                    if (i_start) begin
                        r_dx    <= dx_abs;
                        r_dy    <= dy_abs;
                        r_state <= SQ_MX;
                    end
                end
                SQ_MX: begin
                    r_prod  <= product;
                    r_state <= SQ_MY;
                end
                SQ_MY: begin
                    r_acc   <= r_prod;
                    r_prod  <= product;
                    r_state <= SQ_SUM;
                end
                SQ_SUM: begin
                    r_acc   <= r_acc + r_prod;
                    r_done  <= 1'b1;
                    r_state <= SQ_IDLE;
                end
                default: begin
                    r_state <= SQ_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sq   = r_acc;

endmodule

`default_nettype wire

// ----- design/ctl_div10.sv -----
// divider by the att constant: shift-add reciprocal estimate, then one correction step
`default_nettype none

module ctl_div10 #(
    parameter int W = 34
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [W-1:0]  i_dividend,
    output logic               o_done,
    output logic [W-1:0]       o_quot
);

    import ctl_pkg::*;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_SEED,
        DV_FOLD4,
        DV_FOLD8,
        DV_FOLD16,
        DV_FOLD32,
        DV_TIMES5,
        DV_FIX
    } t_dv_state;

    t_dv_state          r_state;
    logic               r_done;
    logic [W-1:0]       r_num;
    logic [W-1:0]       r_q;
    logic [3:0]         r_q5_lo;

    logic [W-1:0]       add_a;
    logic [W-1:0]       add_b;
    logic [W-1:0]       add_sum;
    logic [W-1:0]       q_div8;
    logic [4:0]         rem;

    always_comb begin
        q_div8 = r_q >> 3;
        // one shared adder: the estimate n * 0.8 is built by folding, then 5q
        case (r_state)
            DV_SEED: begin
                add_a = r_num >> 1;
                add_b = r_num >> 2;
            end
            DV_FOLD4: begin
                add_a = r_q;
                add_b = r_q >> 4;
            end
            DV_FOLD8: begin
                add_a = r_q;
                add_b = r_q >> 8;
            end
            DV_FOLD16: begin
                add_a = r_q;
                add_b = r_q >> 16;
            end
            DV_FOLD32: begin
                add_a = r_q;
                add_b = r_q >> 32;
            end
            DV_TIMES5: begin
                add_a = q_div8;
                add_b = q_div8 << 2;
            end
            default: begin
                add_a = '0;
                add_b = '0;
            end
        endcase
        add_sum = add_a + add_b;
        // estimate is at most one low, so n - 10q is below 20 and fits in five bits
        rem = r_num[4:0] - {r_q5_lo, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_dividend;
                        r_state <= DV_SEED;
                    end
                end
                DV_SEED: begin
                    r_q     <= add_sum;
                    r_state <= DV_FOLD4;
                end
                DV_FOLD4: begin
                    r_q     <= add_sum;
                    r_state <= DV_FOLD8;
                end
                DV_FOLD8: begin
                    r_q     <= add_sum;
                    r_state <= DV_FOLD16;
                end
                DV_FOLD16: begin
                    r_q     <= add_sum;
                    r_state <= DV_FOLD32;
                end
                DV_FOLD32: begin
                    r_q     <= add_sum;
                    r_state <= DV_TIMES5;
                end
                DV_TIMES5: begin
                    r_q     <= q_div8;
                    r_q5_lo <= add_sum[3:0];
                    r_state <= DV_FIX;
                end
                DV_FIX: begin
                    r_q     <= r_q + W'(rem >= 5'(CTL_ATT_DIV));
                    r_done  <= 1'b1;
                    r_state <= DV_IDLE;
                end
                default: begin
                    r_state <= DV_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == DV_IDLE)
        else $error("divider restarted while running");

endmodule

`default_nettype wire

// ----- design/ctl_isqrt.sv -----
// iterative integer square root, one result bit per cycle
`default_nettype none

module ctl_isqrt #(
    parameter int W = 50
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [W-1:0]  i_value,
    output logic               o_done,
    output logic [W/2-1:0]     o_root,
    output logic               o_rem_nz
);

    typedef enum logic {
        RT_IDLE,
        RT_RUN
    } t_rt_state;

    t_rt_state      r_state;
    logic           r_done;
    logic [W-1:0]   r_v;
    logic [W-1:0]   r_res;
    logic [W-1:0]   r_bit;

    logic [W:0]     trial;
    logic           take;

    always_comb begin
        trial = {1'b0, r_res} + {1'b0, r_bit};
        take  = ({1'b0, r_v} >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RT_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                RT_IDLE: begin
                    if (i_start) begin
                        r_v     <= i_value;
                        r_res   <= '0;
                        r_bit   <= {2'b01, {(W-2){1'b0}}};
                        r_state <= RT_RUN;
                    end
                end
                RT_RUN: begin
                    if (take) begin
                        r_v   <= r_v - trial[W-1:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_done  <= 1'b1;
                        r_state <= RT_IDLE;
                    end
                end
                default: begin
                    r_state <= RT_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_root   = r_res[W/2-1:0];
    // leftover value - root^2, nonzero when the root was rounded down
    assign o_rem_nz = |r_v;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == RT_IDLE)
        else $error("square root restarted while running");

    a_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == RT_RUN |-> $onehot(r_bit))
        else $error("square root bit marker lost");

endmodule

`default_nettype wire

// ----- design/closed_tour_length.sv -----
// closed tour length: top level with the leg sequencer and running sum
// a first city is only stored (a one-city tour goes to emit); every later city runs one leg, a final one two
// a euclidean leg runs the squared distance unit, then the bit-serial square root
// an att leg adds the shift-add divide by ten between the two
// throughput: one city at a time, the input stalls until the city's legs are summed and a final result is emitted
// reset: synchronous active-low; clears the sequencer, tour state, output valid and distance mode
`default_nettype none

module closed_tour_length #(
    parameter int FRAC_BITS = ctl_pkg::CTL_FRAC_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ctl_pkg::t_ctl_in  i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output ctl_pkg::t_ctl_out      o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_data
);

    import ctl_pkg::*;

    localparam int SQ_W    = CTL_SQ_W;
    localparam int DIV_W   = (SQ_W - 2*FRAC_BITS > 5) ? (SQ_W - 2*FRAC_BITS) : 5;
    localparam int LEG_W   = CTL_ROOT_W + 1 + FRAC_BITS;
    localparam int ADD_W   = ((CTL_SUM_W > LEG_W) ? CTL_SUM_W : LEG_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_GO,
        S_SQ_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RT_GO,
        S_RT_WAIT,
        S_ADD,
        S_EMIT
    } t_state;

    t_state                   r_state;
    t_ctl_mode                r_mode;
    logic                     r_started;
    logic                     r_fin;
    logic                     r_closing;
    logic [CTL_COORD_W-1:0]   r_first_x;
    logic [CTL_COORD_W-1:0]   r_first_y;
    logic [CTL_COORD_W-1:0]   r_prev_x;
    logic [CTL_COORD_W-1:0]   r_prev_y;
    logic [CTL_COORD_W-1:0]   r_ax;
    logic [CTL_COORD_W-1:0]   r_ay;
    logic [CTL_COORD_W-1:0]   r_bx;
    logic [CTL_COORD_W-1:0]   r_by;
    logic [CTL_SUM_W-1:0]     r_sum;
    logic                     r_sat;
    logic                     r_out_valid;
    t_ctl_out                 r_out;

    logic                     in_take;
    logic                     out_free;
    logic                     sq_done;
    logic [SQ_W-1:0]          sq_val;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quot;
    logic                     rt_done;
    logic [CTL_ROOT_W-1:0]    rt_root;
    logic                     rt_rem_nz;

    logic [SQ_W-1:0]          sq_shift;
    logic                     sq_low_nz;
    logic [SQ_W:0]            div_sum;
    logic [DIV_W-1:0]         div_in;
    logic [SQ_W-1:0]          rt_in;
    logic [CTL_ROOT_W:0]      root_up;
    logic [ADD_W-1:0]         leg_len;
    logic [ADD_W-1:0]         sum_ext;
    logic                     sum_over;

    assign in_take     = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        // att: ceil(s / (10 * 2^2F)) as ceil(ceil(s / 2^2F) / 10)
        sq_shift  = sq_val >> (2*FRAC_BITS);
        sq_low_nz = |(sq_val & ~({SQ_W{1'b1}} << (2*FRAC_BITS)));
        div_sum   = {1'b0, sq_shift} + (SQ_W+1)'(sq_low_nz) + (SQ_W+1)'(CTL_ATT_DIV - 1);
        div_in    = div_sum[DIV_W-1:0];
        rt_in     = (r_mode == MODE_ATT) ? SQ_W'(div_quot) : sq_val;
        root_up   = (CTL_ROOT_W+1)'(rt_root) + (CTL_ROOT_W+1)'(rt_rem_nz);
        leg_len   = (r_mode == MODE_ATT) ? (ADD_W'(root_up) << FRAC_BITS) : ADD_W'(rt_root);
        sum_ext   = ADD_W'(r_sum) + leg_len;
        sum_over  = (sum_ext > ADD_W'(CTL_SUM_MAX));
    end

    ctl_sqdist #(
        .CW (CTL_COORD_W)
    ) u_sqdist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQ_GO),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_bx    (r_bx),
        .i_by    (r_by),
        .o_done  (sq_done),
        .o_sq    (sq_val)
    );

    ctl_div10 #(
        .W (DIV_W)
    ) u_div10 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIV_GO),
        .i_dividend (div_in),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    ctl_isqrt #(
        .W (SQ_W)
    ) u_isqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_RT_GO),
        .i_value  (rt_in),
        .o_done   (rt_done),
        .o_root   (rt_root),
        .o_rem_nz (rt_rem_nz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_EUC;
            r_started   <= 1'b0;
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= t_ctl_mode'(i_cfg_data);
            end
            // the emit step reloads the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_prev_x <= i_in.city_x;
                        r_prev_y <= i_in.city_y;
                        r_fin    <= i_in.is_final;
                        if (!r_started) begin
                            // first city: closing leg of a one-city tour is zero
                            r_first_x <= i_in.city_x;
                            r_first_y <= i_in.city_y;
                            r_sum     <= '0;
                            r_sat     <= 1'b0;
                            r_started <= 1'b1;
                            if (i_in.is_final) begin
                                r_state <= S_EMIT;
                            end
                        end else begin
                            r_ax      <= r_prev_x;
                            r_ay      <= r_prev_y;
                            r_bx      <= i_in.city_x;
                            r_by      <= i_in.city_y;
                            r_closing <= 1'b0;
                            r_state   <= S_SQ_GO;
                        end
                    end
                end
                S_SQ_GO: begin
                    r_state <= S_SQ_WAIT;
                end
                S_SQ_WAIT: begin
                    if (sq_done) begin
                        r_state <= (r_mode == MODE_ATT) ? S_DIV_GO : S_RT_GO;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_state <= S_RT_GO;
                    end
                end
                S_RT_GO: begin
                    r_state <= S_RT_WAIT;
                end
                S_RT_WAIT: begin
                    if (rt_done) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (sum_over) begin
                        r_sum <= CTL_SUM_MAX;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= sum_ext[CTL_SUM_W-1:0];
                    end
                    if (r_fin && !r_closing) begin
                        // closing leg from the last city back to the first
                        r_ax      <= r_prev_x;
                        r_ay      <= r_prev_y;
                        r_bx      <= r_first_x;
                        r_by      <= r_first_y;
                        r_closing <= 1'b1;
                        r_state   <= S_SQ_GO;
                    end else if (r_fin) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out.total_length <= r_sum;
                        r_out.overflowed   <= r_sat;
                        r_out_valid        <= 1'b1;
                        r_first_x          <= '0;
                        r_first_y          <= '0;
                        r_prev_x           <= '0;
                        r_prev_y           <= '0;
                        r_sum              <= '0;
                        r_sat              <= 1'b0;
                        r_started          <= 1'b0;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_sat_pinned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> r_sum == CTL_SUM_MAX)
        else $error("saturation flag set with sum below maximum");

    a_idle_tour_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_sum == '0) && !r_sat)
        else $error("tour state left over with no tour started");

    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result raised outside the emit step");

endmodule

`default_nettype wire
